FILE: rtl/mcvs_pkg.sv
// Shared types, constants and color table for the memory map and video scan block.
package mcvs_pkg;

  localparam int MAIN_BYTES_DEF = 24576;
  localparam int SCREEN_COLUMNS = 224;
  localparam int COLOR_BYTES    = 2048;
  localparam int CIDX_W         = 11;

  localparam logic [15:0] COLOR_BASE = 16'hC400;
  localparam logic [15:0] VIDEO_BASE = 16'h2400;
  localparam logic [15:0] WRITE_LO   = 16'h2000;
  localparam logic [15:0] WRITE_HI   = 16'h4000;
  localparam logic [31:0] BACKGROUND = 32'hFFFF0000;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_LOAD  = 2'd2,
    OP_FETCH = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SEND
  } state_t;

  typedef enum logic [1:0] {
    SRC_MAIN,
    SRC_COLOR,
    SRC_ZERO
  } src_t;

  // Fold a color region offset into the 11-bit attribute index
  function automatic logic [CIDX_W-1:0] fold_index(input logic [15:0] off);
    fold_index = {off[12:7], off[4:0]};
  endfunction

  // ARGB color for a set display bit
  function automatic logic [31:0] palette(input logic [2:0] idx);
    logic [31:0] c;
    case (idx)
      3'd0:    c = 32'h00FF8080;
      3'd1:    c = 32'hFF0000FF;
      3'd2:    c = 32'hFFFF0000;
      3'd3:    c = 32'hFFFF00FF;
      3'd4:    c = 32'hFF00FF00;
      3'd5:    c = 32'hFF00FFFF;
      3'd6:    c = 32'hFFFFFF00;
      default: c = 32'hFFFFFFFF;
    endcase
    palette = c;
  endfunction

endpackage

FILE: rtl/memory_map_color_ram_video_scan_unit.sv
// Memory map, color attribute RAM and video byte fetch for an 8080 bitmap board.

// After reset the block runs a clearing pass over all main entries (both stores are
// zeroed together, one entry per cycle) and accepts no transaction until it ends.
// Then a cpu write or rom load is accepted and produces nothing. A cpu read passes
// through the accept, the registered memory read and then one result. A video fetch
// passes through the same steps and then emits eight pixel results, one per cycle
// unless out_stall holds them, bit 0 first; an off-screen fetch is dropped on accept.
// This order comes from the single read port of each store and the one-entry result
// register; a new transaction is accepted once the last result has been taken.
module memory_map_color_ram_video_scan_unit
  import mcvs_pkg::*;
#(
  parameter int MAIN_BYTES = MAIN_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  op,
  input  logic [15:0] address,
  input  logic [7:0]  wdata,
  input  logic [7:0]  column,
  input  logic [4:0]  byte_row,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  rdata,
  output logic [7:0]  pixel_x,
  output logic [7:0]  pixel_y,
  output logic [31:0] pixel_color,
  output logic        is_pixel,
  output logic        last
);

  localparam int MW = $clog2(MAIN_BYTES);

  // Stores
  logic [7:0] main_mem  [MAIN_BYTES];
  logic [7:0] color_mem [COLOR_BYTES];

  // Control registers
  state_t        state, state_next;
  logic [MW-1:0] clr_idx;
  logic [2:0]    bit_cnt;

  // Transaction registers
  logic              is_pixel_q;
  src_t              src_q;
  logic [7:0]        column_q;
  logic [4:0]        row_q;
  logic [7:0]        rdata_q;
  logic [7:0]        vbyte_q;
  logic [2:0]        color_q;

  // Memory ports
  logic              main_we, color_we;
  logic [MW-1:0]     main_waddr, main_raddr;
  logic [CIDX_W-1:0] color_waddr, color_raddr;
  logic [7:0]        main_wdata, color_wdata;
  logic [7:0]        main_rd, color_rd;

  // Decode
  logic        in_acc, out_acc, clr_done, on_screen, addr_in_main, disp_in_main;
  logic        addr_in_color, addr_writable, last_int;
  logic [15:0] color_off, disp_addr;
  logic [7:0]  sel_byte;
  op_t         op_in;

  assign op_in         = op_t'(op);
  assign in_acc        = in_valid && !in_stall;
  assign out_acc       = out_valid && !out_stall;
  assign clr_done      = (clr_idx == MW'(MAIN_BYTES - 1));
  assign on_screen     = ({1'b0, column} < 9'(SCREEN_COLUMNS));
  assign addr_in_main  = ({1'b0, address} < 17'(MAIN_BYTES));
  assign addr_in_color = (address >= COLOR_BASE);
  assign addr_writable = (address >= WRITE_LO) && (address < WRITE_HI) && addr_in_main;
  assign color_off     = address - COLOR_BASE;
  assign disp_addr     = VIDEO_BASE + {3'b000, column, byte_row};
  assign disp_in_main  = ({1'b0, disp_addr} < 17'(MAIN_BYTES));
  assign last_int      = is_pixel_q ? (bit_cnt == 3'd7) : 1'b1;

  // Select memory write and read ports
  always_comb begin
    main_we     = 1'b0;
    main_waddr  = address[MW-1:0];
    main_wdata  = wdata;
    color_we    = 1'b0;
    color_waddr = fold_index(color_off);
    color_wdata = wdata;
    if (op_in == OP_FETCH) begin
      main_raddr  = disp_addr[MW-1:0];
      color_raddr = fold_index({3'b000, column, byte_row});
    end else begin
      main_raddr  = address[MW-1:0];
      color_raddr = fold_index(color_off);
    end
    if (state == ST_CLEAR) begin
      main_we     = 1'b1;
      main_waddr  = clr_idx;
      main_wdata  = 8'd0;
      color_we    = (clr_idx < MW'(COLOR_BYTES));
      color_waddr = clr_idx[CIDX_W-1:0];
      color_wdata = 8'd0;
    end else if (in_acc) begin
      case (op_in)
        OP_WRITE: begin
          color_we = addr_in_color;
          main_we  = !addr_in_color && addr_writable;
        end
        OP_LOAD: main_we = addr_in_main;
        default: ;
      endcase
    end
  end

  // Main store: one write port, registered read
  always_ff @(posedge clk) begin
    if (main_we) begin
      main_mem[main_waddr] <= main_wdata;
    end
    main_rd <= main_mem[main_raddr];
  end

  // Color store: one write port, registered read
  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[color_waddr] <= color_wdata;
    end
    color_rd <= color_mem[color_raddr];
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: if (clr_done) state_next = ST_IDLE;
      ST_IDLE: begin
        if (in_acc && (op_in == OP_READ || (op_in == OP_FETCH && on_screen))) begin
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: state_next = ST_SEND;
      ST_SEND:  if (out_acc && last_int) state_next = ST_IDLE;
      default:  state_next = ST_CLEAR;
    endcase
  end

  // Handshake outputs
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_IDLE:  in_stall  = 1'b0;
      ST_SEND:  out_valid = 1'b1;
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_idx <= clr_idx + MW'(1);
      end
    end
  end

  // Pick the byte delivered by the memory read
  always_comb begin
    case (src_q)
      SRC_MAIN:  sel_byte = main_rd;
      SRC_COLOR: sel_byte = color_rd;
      default:   sel_byte = 8'd0;
    endcase
  end

  // Capture the transaction, then the read data, then advance through the pixels
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_acc) begin
      is_pixel_q <= (op_in == OP_FETCH);
      column_q   <= column;
      row_q      <= byte_row;
      if (op_in == OP_FETCH) begin
        src_q <= disp_in_main ? SRC_MAIN : SRC_ZERO;
      end else if (addr_in_color) begin
        src_q <= SRC_COLOR;
      end else begin
        src_q <= addr_in_main ? SRC_MAIN : SRC_ZERO;
      end
    end
    if (state == ST_FETCH) begin
      rdata_q <= is_pixel_q ? 8'd0 : sel_byte;
      vbyte_q <= sel_byte;
      color_q <= color_rd[2:0];
      bit_cnt <= 3'd0;
    end else if (out_acc) begin
      bit_cnt <= bit_cnt + 3'd1;
    end
  end

  // Result fields
  assign rdata       = rdata_q;
  assign is_pixel    = is_pixel_q;
  assign last        = last_int;
  assign pixel_x     = is_pixel_q ? column_q : 8'd0;
  assign pixel_y     = is_pixel_q ? ~{row_q, bit_cnt} : 8'd0;
  assign pixel_color = !is_pixel_q      ? 32'd0 :
                       vbyte_q[bit_cnt] ? palette(color_q) : BACKGROUND;

endmodule
